### sv/png_unf_pkg.sv
// Package for the PNG scanline unfilter block: item types, filter, colour mode
// and register index codes, and default sizes. No dependencies.
`default_nettype none

package png_unf_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int WIDTH_REG_W = 13;
    localparam int HEIGHT_W    = 16;
    localparam int MODE_W      = 2;
    localparam int FILTER_W    = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE   = 2'd2;

    // colour modes; the fourth code is taken as RGBA
    localparam logic [MODE_W-1:0] COLOR_GRAY = 2'd0;
    localparam logic [MODE_W-1:0] COLOR_RGB  = 2'd1;
    localparam logic [MODE_W-1:0] COLOR_RGBA = 2'd2;

    // row filter types
    localparam logic [FILTER_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILTER_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [FILTER_W-1:0] FILT_UP    = 3'd2;
    localparam logic [FILTER_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [FILTER_W-1:0] FILT_PAETH = 3'd4;

    localparam logic [7:0] OPAQUE = 8'hff;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       bad_filter;
        logic       last_pixel;
    } out_item_t;

endpackage

`default_nettype wire

### sv/png_unf_row_mem.sv
// Prior row store: single write port, one registered read port.
// Depends on png_unf_pkg for the default size; sized by the top level.
`default_nettype none

module png_unf_row_mem #(
    parameter int DEPTH  = png_unf_pkg::MAX_WIDTH_DEF * 4,
    parameter int ADDR_W = $clog2(png_unf_pkg::MAX_WIDTH_DEF * 4)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read every cycle; a read of the entry written at the same edge returns old data
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/png_unf_recon.sv
// Byte reconstruction for the five PNG filter types, Paeth predictor included.
// Depends on png_unf_pkg for the filter codes.
`default_nettype none

module png_unf_recon (
    input  wire logic [png_unf_pkg::FILTER_W-1:0] filter,
    input  wire logic [7:0]                       sample,
    input  wire logic [7:0]                       left,
    input  wire logic [7:0]                       up,
    input  wire logic [7:0]                       upleft,
    output logic      [7:0]                       recon
);

    logic [8:0] sum_ab;
    logic [9:0] sum_abx;
    logic [9:0] two_c;
    logic [8:0] dist_a;
    logic [8:0] dist_b;
    logic [9:0] dist_c;
    logic [7:0] paeth;
    logic [7:0] avg;

    // |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    always_comb begin
        sum_ab  = {1'b0, left} + {1'b0, up};
        sum_abx = {1'b0, sum_ab};
        two_c   = {1'b0, upleft, 1'b0};
        dist_a  = (up > upleft) ? {1'b0, up - upleft} : {1'b0, upleft - up};
        dist_b  = (left > upleft) ? {1'b0, left - upleft} : {1'b0, upleft - left};
        dist_c  = (sum_abx > two_c) ? (sum_abx - two_c) : (two_c - sum_abx);
        if ((dist_a <= dist_b) && ({1'b0, dist_a} <= dist_c)) begin
            paeth = left;
        end else if ({1'b0, dist_b} <= dist_c) begin
            paeth = up;
        end else begin
            paeth = upleft;
        end
        avg = sum_ab[8:1];
    end

    always_comb begin
        case (filter)
            png_unf_pkg::FILT_SUB:   recon = sample + left;
            png_unf_pkg::FILT_UP:    recon = sample + up;
            png_unf_pkg::FILT_AVG:   recon = sample + avg;
            png_unf_pkg::FILT_PAETH: recon = sample + paeth;
            default:                 recon = sample;
        endcase
    end

endmodule

`default_nettype wire

### sv/png_unf_outq.sv
// Two-entry result queue between the unfilter datapath and the result channel.
// Depends on png_unf_pkg for the result item type.
`default_nettype none

module png_unf_outq (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire png_unf_pkg::out_item_t push_data,
    output logic                        full,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output png_unf_pkg::out_item_t      m_data
);

    png_unf_pkg::out_item_t ent_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign m_data  = ent_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### sv/png_scanline_unfilter_rgba_top.sv
// PNG scanline unfilter with RGBA expansion: control, row state and registers.
// Depends on png_unf_pkg, png_unf_row_mem, png_unf_recon and png_unf_outq.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    in_item_t  (data_byte, image_start)
//   m_        out        m_valid/m_ready    out_item_t (RGBA, bad_filter, last_pixel)
//   cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// One byte is taken every cycle while s_ready is high. The row store is read
// ahead at the next column, so its registered read does not slow the stream.
// A pixel leaves through a two-entry queue, which takes it with its last byte.
// s_ready drops only while both queue entries are held by a stalled m_ side.
// Reset clears all control state; the row store has no clearing pass.
`default_nettype none

module png_scanline_unfilter_rgba_top #(
    parameter int MAX_WIDTH = png_unf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire png_unf_pkg::in_item_t                 s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output png_unf_pkg::out_item_t                     m_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [png_unf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [png_unf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH    = MAX_WIDTH * 4;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int STRIDE_W = ADDR_W + 1;
    localparam int HW       = png_unf_pkg::HEIGHT_W;

    // configuration registers
    logic [png_unf_pkg::WIDTH_REG_W-1:0] width_reg;
    logic [HW-1:0]                       height_reg;
    logic [png_unf_pkg::MODE_W-1:0]      mode_reg;

    // row state
    logic [31:0]                         left_reg, left_next;
    logic [31:0]                         upleft_reg, upleft_next;
    logic [ADDR_W-1:0]                   col_reg, col_next;
    logic [HW-1:0]                       row_reg, row_next;
    logic [png_unf_pkg::FILTER_W-1:0]    filter_reg, filter_next;
    logic                                await_reg, await_next;
    logic                                first_reg, first_next;
    logic [23:0]                         gather_reg, gather_next;
    logic [1:0]                          chan_reg, chan_next;
    logic                                err_reg, err_next;

    logic                                acc;
    logic                                full;
    logic [31:0]                         width32;
    logic [31:0]                         stride32;
    logic [STRIDE_W-1:0]                 stride;
    logic [HW-1:0]                       height_eff;
    logic [2:0]                          chans;
    logic [7:0]                          up;
    logic [7:0]                          left;
    logic [7:0]                          upleft;
    logic [7:0]                          recon;
    logic [7:0]                          rd_data;
    logic                                row_done;
    logic                                last;
    logic                                mem_we;
    logic                                res_valid;
    png_unf_pkg::out_item_t              res;

    assign cfg_ready = 1'b1;
    assign s_ready   = !full;
    assign acc       = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= png_unf_pkg::WIDTH_REG_W'(1);
            height_reg <= HW'(1);
            mode_reg   <= png_unf_pkg::COLOR_RGBA;
        end else if (cfg_valid) begin
            case (cfg_index)
                png_unf_pkg::CFG_IMAGE_WIDTH:
                    width_reg <= cfg_data[png_unf_pkg::WIDTH_REG_W-1:0];
                png_unf_pkg::CFG_IMAGE_HEIGHT:
                    height_reg <= cfg_data[HW-1:0];
                png_unf_pkg::CFG_COLOR_MODE:
                    mode_reg <= cfg_data[png_unf_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective row size in bytes, channel count, height and neighbour bytes
    always_comb begin
        width32 = 32'(width_reg);
        if (width32 == 32'd0) begin
            width32 = 32'd1;
        end else if (width32 > 32'(MAX_WIDTH)) begin
            width32 = 32'(MAX_WIDTH);
        end
        case (mode_reg)
            png_unf_pkg::COLOR_GRAY: begin
                chans    = 3'd1;
                stride32 = width32;
                left     = left_reg[7:0];
                upleft   = upleft_reg[7:0];
            end
            png_unf_pkg::COLOR_RGB: begin
                chans    = 3'd3;
                stride32 = width32 + (width32 << 1);
                left     = left_reg[23:16];
                upleft   = upleft_reg[23:16];
            end
            default: begin
                chans    = 3'd4;
                stride32 = width32 << 2;
                left     = left_reg[31:24];
                upleft   = upleft_reg[31:24];
            end
        endcase
        stride     = stride32[STRIDE_W-1:0];
        height_eff = (height_reg == '0) ? HW'(1) : height_reg;
        up         = first_reg ? 8'd0 : rd_data;
    end

    png_unf_recon u_recon (
        .filter (filter_reg),
        .sample (s_data.data_byte),
        .left   (left),
        .up     (up),
        .upleft (upleft),
        .recon  (recon)
    );

    always_comb begin
        left_next   = left_reg;
        upleft_next = upleft_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        filter_next = filter_reg;
        await_next  = await_reg;
        first_next  = first_reg;
        gather_next = gather_reg;
        chan_next   = chan_reg;
        err_next    = err_reg;
        mem_we      = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        row_done    = ({1'b0, col_reg} + STRIDE_W'(1)) >= stride;
        last        = row_done && (({1'b0, row_reg} + 17'd1) >= {1'b0, height_eff});

        if (acc && (s_data.image_start || !err_reg)) begin
            if (s_data.image_start || await_reg) begin
                // filter byte; image start also drops any image in progress
                err_next    = 1'b0;
                if (s_data.image_start) begin
                    first_next = 1'b1;
                    row_next   = '0;
                end
                left_next   = '0;
                upleft_next = '0;
                col_next    = '0;
                gather_next = '0;
                chan_next   = '0;
                if (s_data.data_byte > 8'(png_unf_pkg::FILT_PAETH)) begin
                    err_next       = 1'b1;
                    await_next     = 1'b1;
                    res_valid      = 1'b1;
                    res.bad_filter = 1'b1;
                end else begin
                    filter_next = s_data.data_byte[png_unf_pkg::FILTER_W-1:0];
                    await_next  = 1'b0;
                end
            end else begin
                mem_we      = 1'b1;
                left_next   = {left_reg[23:0], recon};
                upleft_next = {upleft_reg[23:0], up};
                if (({1'b0, chan_reg} + 3'd1) >= chans) begin
                    res_valid = 1'b1;
                    case (chans)
                        3'd1: begin
                            res.red   = recon;
                            res.green = recon;
                            res.blue  = recon;
                            res.alpha = png_unf_pkg::OPAQUE;
                        end
                        3'd3: begin
                            res.red   = gather_reg[7:0];
                            res.green = gather_reg[15:8];
                            res.blue  = recon;
                            res.alpha = png_unf_pkg::OPAQUE;
                        end
                        default: begin
                            res.red   = gather_reg[7:0];
                            res.green = gather_reg[15:8];
                            res.blue  = gather_reg[23:16];
                            res.alpha = recon;
                        end
                    endcase
                    res.last_pixel = last;
                    gather_next    = '0;
                    chan_next      = '0;
                end else begin
                    gather_next = gather_reg | (24'(recon) << {chan_reg, 3'b000});
                    chan_next   = chan_reg + 2'd1;
                end
                if (row_done) begin
                    await_next = 1'b1;
                    col_next   = '0;
                    if (last) begin
                        first_next  = 1'b1;
                        row_next    = '0;
                        left_next   = '0;
                        upleft_next = '0;
                        gather_next = '0;
                        chan_next   = '0;
                    end else begin
                        first_next = 1'b0;
                        row_next   = row_reg + HW'(1);
                    end
                end else begin
                    col_next = col_reg + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            upleft_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            filter_reg <= png_unf_pkg::FILT_NONE;
            await_reg  <= 1'b1;
            first_reg  <= 1'b1;
            gather_reg <= '0;
            chan_reg   <= '0;
            err_reg    <= 1'b0;
        end else begin
            left_reg   <= left_next;
            upleft_reg <= upleft_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            filter_reg <= filter_next;
            await_reg  <= await_next;
            first_reg  <= first_next;
            gather_reg <= gather_next;
            chan_reg   <= chan_next;
            err_reg    <= err_next;
        end
    end

    // read ahead at the column the next byte will use
    png_unf_row_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_row_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (col_reg),
        .wr_data (recon),
        .rd_addr (col_next),
        .rd_data (rd_data)
    );

    png_unf_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .full      (full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    a_res_only_on_item: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> acc)
        else $error("result produced without an accepted item");

    a_hold_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && err_reg && !s_data.image_start) |-> !res_valid)
        else $error("result produced during error hold");

    a_bad_filter_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.bad_filter) |-> (res.red == 8'd0 && res.green == 8'd0 &&
        res.blue == 8'd0 && res.alpha == 8'd0 && !res.last_pixel))
        else $error("bad filter result carries pixel data");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.last_pixel) |=> (await_reg && first_reg && row_reg == '0))
        else $error("image end did not return to first row filter byte");
`endif

endmodule

`default_nettype wire
